@@ rtl/kmm_pkg.sv @@
// ----------------------------------------------------------------------------
// kmm_pkg
// Shared types and constants of the keyed min/max/sum aggregator.
// ----------------------------------------------------------------------------
package kmm_pkg;

	localparam int NUM_SLOTS = 64;
	localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int USED_W    = $clog2(NUM_SLOTS + 1);

	// Fahrenheit in units of 1e-4 degree: millikelvin * 18 - 4596700.
	localparam logic [23:0] TEMP_OFFSET = 24'd4596700;
	localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

	// Milliseconds to seconds: drop three bits (divide by 8), then multiply by
	// the reciprocal of 125 scaled by 2^45. This is exact for every 38-bit
	// dividend. The constant is applied ten bits a cycle, top slice first.
	localparam logic [39:0] RECIP_M     = 40'd281474976711;
	localparam int          RECIP_SHIFT = 45;
	localparam int          RECIP_ITERS = 4;

	typedef enum logic [1:0] {
		ST_UPDATED = 2'd0,
		ST_CREATED = 2'd1,
		ST_FULL    = 2'd2,
		ST_SATUR   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_SEND
	} front_state_t;

	typedef enum logic {
		B_IDLE,
		B_CALC
	} back_state_t;

	typedef struct packed {
		logic [15:0] state_code;
		logic [40:0] time_ms;
		logic [9:0]  humidity_tenths;
		logic        snow_flag;
		logic [9:0]  cloud_tenths;
		logic        lightning_flag;
		logic [18:0] temp_millikelvin;
	} item_t;

	typedef struct packed {
		logic [5:0]         slot;
		status_t            status;
		logic [31:0]        record_count;
		logic signed [23:0] hi_temp;
		logic [31:0]        max_time;
		logic signed [23:0] lo_temp;
		logic [31:0]        min_time;
		logic [31:0]        lightning_count;
		logic [31:0]        snow_count;
		logic signed [55:0] temp_sum;
		logic [41:0]        humidity_sum;
		logic [41:0]        cloud_sum;
	} result_t;

	// One classified request from the front part to the back part.
	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		status_t            kind;   // updated, created or full
		logic signed [23:0] temp;
		logic [31:0]        sec;
		logic [9:0]         hum;
		logic [9:0]         cloud;
		logic               snow;
		logic               light;
	} job_t;

	// One slot's aggregates as held in the slot memory.
	typedef struct packed {
		logic [31:0]        count;
		logic signed [23:0] hi_temp;
		logic [31:0]        max_time;
		logic signed [23:0] lo_temp;
		logic [31:0]        min_time;
		logic [31:0]        lightning;
		logic [31:0]        snow;
		logic signed [55:0] temp_sum;
		logic [42:0]        hum_sum;
		logic [42:0]        cloud_sum;
	} agg_t;

	localparam int AGG_W = $bits(agg_t);

endpackage

@@ rtl/kmm_ram.sv @@
// ----------------------------------------------------------------------------
// kmm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kmm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/kmm_front.sv @@
// ----------------------------------------------------------------------------
// kmm_front
// Accepts a record, converts time and temperature, and classifies its key
// against the slot table as updated, created or table full.
// ----------------------------------------------------------------------------
module kmm_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  kmm_pkg::item_t item,
	output logic           job_valid,
	input  logic           job_ready,
	output kmm_pkg::job_t  job
);
	import kmm_pkg::*;

	front_state_t state_q, state_d;
	item_t        item_q;
	logic [37:0]  x_q;
	logic [39:0]  m_q;
	logic [76:0]  acc_q;
	logic [1:0]   cnt_q;
	logic [47:0]  part;

	logic [15:0]       key_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] valid_q;
	logic [USED_W-1:0] used_q;
	logic [NUM_SLOTS-1:0] hit;
	logic [SLOT_W-1:0] hit_idx;
	logic              found;
	logic [23:0]       temp_raw;
	logic              accept, send;

	assign accept = push && !full;
	assign send   = (state_q == F_SEND) && job_ready;

	// Seconds by reciprocal multiplication, one ten-bit slice of the constant a cycle.
	assign part = {10'd0, x_q} * {38'd0, m_q[39:30]};

	// Key lookup: keys are unique, so an OR of the matching indexes gives the hit.
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			hit[i] = valid_q[i] && (key_q[i] == item_q.state_code);
			if (hit[i]) begin
				hit_idx = hit_idx | SLOT_W'(i);
			end
		end
		found = |hit;
	end

	// Temperature: mk * 18 as two shifts, then the offset.
	assign temp_raw = ({5'd0, item_q.temp_millikelvin} << 4)
	                + ({5'd0, item_q.temp_millikelvin} << 1) - TEMP_OFFSET;

	// Classified request toward the back part.
	always_comb begin
		job.temp  = signed'(temp_raw);
		job.sec   = acc_q[RECIP_SHIFT +: 32];
		job.hum   = item_q.humidity_tenths;
		job.cloud = item_q.cloud_tenths;
		job.snow  = item_q.snow_flag;
		job.light = item_q.lightning_flag;
		if (found) begin
			job.kind = ST_UPDATED;
			job.slot = hit_idx;
		end else if (used_q >= USED_W'(NUM_SLOTS)) begin
			job.kind = ST_FULL;
			job.slot = '0;
		end else begin
			job.kind = ST_CREATED;
			job.slot = SLOT_W'(used_q);
		end
	end

	assign job_valid = (state_q == F_SEND);
	assign full      = (state_q != F_IDLE);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: if (push) state_d = F_DIV;
			F_DIV:  if (cnt_q == '0) state_d = F_SEND;
			F_SEND: if (job_ready) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			valid_q <= '0;
			used_q  <= '0;
		end else begin
			state_q <= state_d;
			if (send && job.kind == ST_CREATED) begin
				valid_q[job.slot] <= 1'b1;
				used_q            <= used_q + 1'b1;
			end
		end
	end

	// Payload registers: record, time multiplier and key table.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
			x_q    <= item.time_ms[40:3];
			m_q    <= RECIP_M;
			acc_q  <= '0;
			cnt_q  <= 2'(RECIP_ITERS - 1);
		end else if (state_q == F_DIV) begin
			acc_q <= {acc_q[66:0], 10'd0} + {29'd0, part};
			m_q   <= {m_q[29:0], 10'd0};
			cnt_q <= cnt_q - 1'b1;
		end
		if (send && job.kind == ST_CREATED) begin
			key_q[job.slot] <= item_q.state_code;
		end
	end

endmodule

@@ rtl/kmm_fifo.sv @@
// ----------------------------------------------------------------------------
// kmm_fifo
// Two-entry request queue between the front and back parts.
// ----------------------------------------------------------------------------
module kmm_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  kmm_pkg::job_t wr_job,
	output logic          rd_valid,
	input  logic          rd_take,
	output kmm_pkg::job_t rd_job
);
	import kmm_pkg::*;

	job_t       buf_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_job   = buf_q[rptr_q];
	assign wr       = wr_valid && wr_ready;
	assign rd       = rd_take && rd_valid;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (wr) wptr_q <= ~wptr_q;
			if (rd) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr) begin
			buf_q[wptr_q] <= wr_job;
		end
	end

endmodule

@@ rtl/kmm_back.sv @@
// ----------------------------------------------------------------------------
// kmm_back
// Reads the slot's aggregates, updates them, writes them back (not for a full-table
// request or a saturated count) and holds the result in an output register.
// ----------------------------------------------------------------------------
module kmm_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	output logic             job_take,
	input  kmm_pkg::job_t    job,
	output logic             empty,
	input  logic             pop,
	output kmm_pkg::result_t result
);
	import kmm_pkg::*;

	back_state_t state_q, state_d;
	job_t        job_q;
	result_t     out_q;
	result_t     full_r;
	logic        out_valid_q;
	logic        out_free, done;
	logic [AGG_W-1:0] rdata;
	agg_t        old_a, new_a;
	logic        ram_we;
	logic signed [55:0] temp_ext;

	assign out_free = !out_valid_q || pop;
	assign job_take = (state_q == B_IDLE) && job_valid;
	assign done     = (state_q == B_CALC) && out_free;
	assign old_a    = agg_t'(rdata);
	assign temp_ext = {{32{job_q.temp[23]}}, job_q.temp};

	kmm_ram #(.WIDTH(AGG_W), .DEPTH(NUM_SLOTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (job_q.slot),
		.wdata (new_a),
		.re    (job_take),
		.raddr (job.slot),
		.rdata (rdata)
	);

	// Result of a dropped full-table request: status only, all else zero.
	always_comb begin
		full_r        = '0;
		full_r.status = ST_FULL;
	end

	// Aggregate update for a new slot or a known one.
	always_comb begin
		new_a = old_a;
		if (job_q.kind == ST_CREATED) begin
			new_a.count     = 32'd1;
			new_a.hi_temp   = job_q.temp;
			new_a.max_time  = job_q.sec;
			new_a.lo_temp   = job_q.temp;
			new_a.min_time  = job_q.sec;
			new_a.lightning = {31'd0, job_q.light};
			new_a.snow      = {31'd0, job_q.snow};
			new_a.temp_sum  = temp_ext;
			new_a.hum_sum   = {33'd0, job_q.hum};
			new_a.cloud_sum = {33'd0, job_q.cloud};
		end else begin
			new_a.count = old_a.count + 32'd1;
			if (job_q.temp > old_a.hi_temp) begin
				new_a.hi_temp  = job_q.temp;
				new_a.max_time = job_q.sec;
			end
			if (job_q.temp < old_a.lo_temp) begin
				new_a.lo_temp  = job_q.temp;
				new_a.min_time = job_q.sec;
			end
			new_a.lightning = old_a.lightning + {31'd0, job_q.light};
			new_a.snow      = old_a.snow + {31'd0, job_q.snow};
			new_a.temp_sum  = old_a.temp_sum + temp_ext;
			new_a.hum_sum   = old_a.hum_sum + {33'd0, job_q.hum};
			new_a.cloud_sum = old_a.cloud_sum + {33'd0, job_q.cloud};
		end
	end

	assign ram_we = done && (job_q.kind == ST_CREATED ||
	                (job_q.kind == ST_UPDATED && old_a.count != COUNT_MAX));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (job_valid) state_d = B_CALC;
			B_CALC: if (out_free) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request capture and result register.
	always_ff @(posedge clk) begin
		if (job_take) begin
			job_q <= job;
		end
		if (done) begin
			if (job_q.kind == ST_FULL) begin
				out_q <= full_r;
			end else begin
				if (ram_we) begin
					out_q.status          <= job_q.kind;
					out_q.record_count    <= new_a.count;
					out_q.hi_temp         <= new_a.hi_temp;
					out_q.max_time        <= new_a.max_time;
					out_q.lo_temp         <= new_a.lo_temp;
					out_q.min_time        <= new_a.min_time;
					out_q.lightning_count <= new_a.lightning;
					out_q.snow_count      <= new_a.snow;
					out_q.temp_sum        <= new_a.temp_sum;
					out_q.humidity_sum    <= new_a.hum_sum[41:0];
					out_q.cloud_sum       <= new_a.cloud_sum[41:0];
				end else begin
					out_q.status          <= ST_SATUR;
					out_q.record_count    <= old_a.count;
					out_q.hi_temp         <= old_a.hi_temp;
					out_q.max_time        <= old_a.max_time;
					out_q.lo_temp         <= old_a.lo_temp;
					out_q.min_time        <= old_a.min_time;
					out_q.lightning_count <= old_a.lightning;
					out_q.snow_count      <= old_a.snow;
					out_q.temp_sum        <= old_a.temp_sum;
					out_q.humidity_sum    <= old_a.hum_sum[41:0];
					out_q.cloud_sum       <= old_a.cloud_sum[41:0];
				end
				out_q.slot <= 6'(job_q.slot);
			end
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

	// The slot memory is written only while a request is being finished.
	a_we_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == B_CALC)
		else $error("slot memory written outside the update step");

	// A dropped full-table request never touches the slot memory.
	a_full_no_we: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_CALC && job_q.kind == ST_FULL) |-> !ram_we)
		else $error("full-table request wrote the slot memory");

	// A new result appears only after an update step.
	a_out_from_calc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == B_CALC))
		else $error("result appeared without an update step");

endmodule

@@ rtl/keyed_min_max_sum_aggregator_unit.sv @@
// ----------------------------------------------------------------------------
// keyed_min_max_sum_aggregator_unit
// Group-by aggregation of weather records by two-character key.
// ----------------------------------------------------------------------------
// Each record passes the front part in steps: it is accepted, then goes through
// the time conversion (milliseconds to seconds by a reciprocal multiply, ten
// bits of the constant a cycle), and then its key is classified against the slot
// table and the request handed on. The back part then reads the slot memory and
// then does the update with write-back. The front part sets the rate and takes
// no new record until it has handed on the last one. Behind an unread result,
// three requests can wait (one in the back part, two in the queue) and a
// fourth in the front part, which then keeps the input full.
// ----------------------------------------------------------------------------
module keyed_min_max_sum_aggregator_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  kmm_pkg::item_t   item,
	output logic             empty,
	input  logic             pop,
	output kmm_pkg::result_t result
);
	import kmm_pkg::*;

	logic f_valid, f_ready, b_valid, b_take;
	job_t f_job, b_job;

	kmm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.job_valid (f_valid),
		.job_ready (f_ready),
		.job       (f_job)
	);

	kmm_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_job   (f_job),
		.rd_valid (b_valid),
		.rd_take  (b_take),
		.rd_job   (b_job)
	);

	kmm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (b_valid),
		.job_take  (b_take),
		.job       (b_job),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

@@ test/kmm_checker.sv @@
// ----------------------------------------------------------------------------
// kmm_checker
// Watches both queues of the aggregator, predicts each result and compares.
// ----------------------------------------------------------------------------
// Every request taken on the input side updates a private copy of the slot
// table. The result it should produce goes into a queue. Every result taken
// on the output side is compared, field by field, with the oldest entry.
// ----------------------------------------------------------------------------
module kmm_checker
	import kmm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  logic    full,
	input  item_t   item,
	input  logic    empty,
	input  logic    pop,
	input  result_t result,
	output int      errors,
	output int      pending
);

	// Private copy of the slot table.
	logic               slot_used_q [NUM_SLOTS];
	logic [15:0]        key_q       [NUM_SLOTS];
	int                 fill_count;
	logic [31:0]        count_q     [NUM_SLOTS];
	logic signed [23:0] hi_temp_q   [NUM_SLOTS];
	logic [31:0]        hi_time_q   [NUM_SLOTS];
	logic signed [23:0] lo_temp_q   [NUM_SLOTS];
	logic [31:0]        lo_time_q   [NUM_SLOTS];
	logic [31:0]        light_q     [NUM_SLOTS];
	logic [31:0]        snow_q      [NUM_SLOTS];
	logic signed [55:0] tsum_q      [NUM_SLOTS];
	logic [42:0]        hsum_q      [NUM_SLOTS];
	logic [42:0]        csum_q      [NUM_SLOTS];

	result_t expected_totals [$];

	assign pending = expected_totals.size();

	// Build the result of one slot from the private table.
	function automatic result_t slot_totals(int s, status_t st);
		result_t r;
		r.slot            = s[5:0];
		r.status          = st;
		r.record_count    = count_q[s];
		r.hi_temp         = hi_temp_q[s];
		r.max_time        = hi_time_q[s];
		r.lo_temp         = lo_temp_q[s];
		r.min_time        = lo_time_q[s];
		r.lightning_count = light_q[s];
		r.snow_count      = snow_q[s];
		r.temp_sum        = tsum_q[s];
		r.humidity_sum    = hsum_q[s][41:0];
		r.cloud_sum       = csum_q[s][41:0];
		return r;
	endfunction

	// Apply one weather record to the table and return the slot's new totals.
	function automatic result_t aggregate_record(item_t d);
		int                 s;
		int                 tf_i;
		logic signed [23:0] tf;
		logic [40:0]        secs;
		result_t            r;
		s = -1;
		tf_i = int'(d.temp_millikelvin) * 18 - 4596700;
		tf = tf_i[23:0];
		secs = d.time_ms / 41'd1000;
		for (int i = 0; i < fill_count; i++) begin
			if (s < 0 && slot_used_q[i] && key_q[i] == d.state_code) begin
				s = i;
			end
		end
		if (s < 0) begin
			// New key with no room left: the record is dropped.
			if (fill_count >= NUM_SLOTS) begin
				r = '0;
				r.status = ST_FULL;
				return r;
			end
			s = fill_count;
			fill_count++;
			slot_used_q[s] = 1'b1;
			key_q[s]       = d.state_code;
			count_q[s]     = 32'd1;
			hi_temp_q[s]   = tf;
			hi_time_q[s]   = secs[31:0];
			lo_temp_q[s]   = tf;
			lo_time_q[s]   = secs[31:0];
			light_q[s]     = 32'(d.lightning_flag);
			snow_q[s]      = 32'(d.snow_flag);
			tsum_q[s]      = 56'(tf);
			hsum_q[s]      = 43'(d.humidity_tenths);
			csum_q[s]      = 43'(d.cloud_tenths);
			return slot_totals(s, ST_CREATED);
		end
		// A saturated count cannot be reached in a run of this length.
		if (count_q[s] == COUNT_MAX) begin
			return slot_totals(s, ST_SATUR);
		end
		count_q[s]++;
		if (tf > hi_temp_q[s]) begin
			hi_temp_q[s] = tf;
			hi_time_q[s] = secs[31:0];
		end
		if (tf < lo_temp_q[s]) begin
			lo_temp_q[s] = tf;
			lo_time_q[s] = secs[31:0];
		end
		light_q[s] += 32'(d.lightning_flag);
		snow_q[s]  += 32'(d.snow_flag);
		tsum_q[s]  += 56'(tf);
		hsum_q[s]  += 43'(d.humidity_tenths);
		csum_q[s]  += 43'(d.cloud_tenths);
		return slot_totals(s, ST_UPDATED);
	endfunction

	// Report one field that differs from its prediction.
	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
		end
	endtask

	// Predict on every accepted request and compare every accepted result.
	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			fill_count = 0;
			errors = 0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_used_q[i] = 1'b0;
			end
			expected_totals.delete();
		end else begin
			if (push && !full) begin
				expected_totals.push_back(aggregate_record(item));
			end
			if (pop && !empty) begin
				if (expected_totals.size() == 0) begin
					errors++;
					$display("%0t: result with none expected, actual %h", $time, result);
				end else begin
					e = expected_totals.pop_front();
					check_field("slot", 64'(e.slot), 64'(result.slot));
					check_field("status", 64'(e.status), 64'(result.status));
					check_field("record_count", 64'(e.record_count), 64'(result.record_count));
					check_field("hi_temp", 64'(e.hi_temp), 64'(result.hi_temp));
					check_field("max_time", 64'(e.max_time), 64'(result.max_time));
					check_field("lo_temp", 64'(e.lo_temp), 64'(result.lo_temp));
					check_field("min_time", 64'(e.min_time), 64'(result.min_time));
					check_field("lightning_count", 64'(e.lightning_count),
						64'(result.lightning_count));
					check_field("snow_count", 64'(e.snow_count), 64'(result.snow_count));
					check_field("temp_sum", 64'(e.temp_sum), 64'(result.temp_sum));
					check_field("humidity_sum", 64'(e.humidity_sum), 64'(result.humidity_sum));
					check_field("cloud_sum", 64'(e.cloud_sum), 64'(result.cloud_sum));
				end
			end
		end
	end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the keyed min/max/sum aggregator.
// ----------------------------------------------------------------------------
// A directed run covers field extremes, equal and new extreme temperatures and
// both flags. Random records then come from a pool of more keys than the table
// holds, so the table fills and later new keys are dropped. The random part
// runs in four phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb;
	import kmm_pkg::*;

	localparam int KEY_POOL   = 80;
	localparam int LIMIT      = 600000;
	localparam int DRAIN_WAIT = 60;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    push;
	logic    full;
	item_t   item;
	logic    empty;
	logic    pop;
	result_t result;
	int      errors;
	int      pending;
	int      idle_pct;
	int      stall_pct;
	int      cycles = 0;
	logic [15:0] keys [KEY_POOL];

	keyed_min_max_sum_aggregator_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	kmm_checker i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.errors  (errors),
		.pending (pending)
	);

	// Clock with a period of four units.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver: stall at random at the current phase's rate.
	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= stall_pct);
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Offer one request, idling first at the current phase's rate.
	task automatic send_record(item_t d);
		while ($urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= d;
		do @(posedge clk); while (full);
	endtask

	task automatic send_fields(logic [15:0] k, logic [40:0] t, logic [9:0] h, logic sn,
			logic [9:0] c, logic lt, logic [18:0] mk);
		item_t d;
		d = '{k, t, h, sn, c, lt, mk};
		send_record(d);
	endtask

	// One random record; ranges mostly realistic, sometimes the full width.
	task automatic send_random();
		item_t d;
		d.state_code       = keys[$urandom_range(KEY_POOL - 1)];
		d.time_ms          = 41'({$urandom, $urandom});
		d.humidity_tenths  = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(1000));
		d.cloud_tenths     = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(1000));
		d.snow_flag        = 1'($urandom_range(1));
		d.lightning_flag   = 1'($urandom_range(1));
		d.temp_millikelvin = ($urandom_range(9) == 0) ? 19'($urandom)
			: 19'($urandom_range(400000));
		send_record(d);
	endtask

	task automatic wait_drained();
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		bit dup;
		push      = 1'b0;
		item      = '0;
		idle_pct  = 0;
		stall_pct = 0;
		arst_n    = 1'b0;

		// Distinct random keys, with the two extremes among them.
		keys[0] = 16'h0000;
		keys[1] = 16'hFFFF;
		for (int i = 2; i < KEY_POOL; i++) begin
			do begin
				keys[i] = 16'($urandom);
				dup = 1'b0;
				for (int j = 0; j < i; j++) begin
					if (keys[j] == keys[i]) dup = 1'b1;
				end
			end while (dup);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, ties on temperature, flags, and several keys.
		send_fields(16'h4341, 41'd0, 10'd0, 1'b0, 10'd0, 1'b0, 19'd0);
		send_fields(16'h4341, 41'h1FF_FFFF_FFFF, 10'd1023, 1'b1, 10'd1023, 1'b1, 19'h7FFFF);
		send_fields(16'h4341, 41'd5000, 10'd500, 1'b1, 10'd1000, 1'b0, 19'h7FFFF);
		send_fields(16'h4341, 41'd999, 10'd1000, 1'b0, 10'd0, 1'b1, 19'd0);
		send_fields(16'h4341, 41'd1000, 10'd1, 1'b0, 10'd1, 1'b0, 19'd255372);
		send_fields(16'h0000, 41'd123456789, 10'd700, 1'b1, 10'd300, 1'b1, 19'd400000);
		send_fields(16'hFFFF, 41'h155_5555_5555, 10'h2AA, 1'b0, 10'h155, 1'b1, 19'h2AAAA);
		send_fields(16'hFFFF, 41'h0AA_AAAA_AAAA, 10'h155, 1'b1, 10'h2AA, 1'b0, 19'h55555);
		send_fields(16'h0000, 41'd1, 10'd0, 1'b0, 10'd0, 1'b0, 19'd1);
		send_fields(16'h0000, 41'd2199023255551, 10'd1000, 1'b1, 10'd1000, 1'b1, 19'd399999);
		send_fields(16'h4E59, 41'd1700000000000, 10'd450, 1'b0, 10'd800, 1'b0, 19'd273150);
		send_fields(16'h4E59, 41'd1700000000001, 10'd450, 1'b0, 10'd800, 1'b0, 19'd273150);
		send_fields(16'h4E59, 41'd1700000003600, 10'd460, 1'b1, 10'd810, 1'b1, 19'd273151);
		send_fields(16'h4E59, 41'd1700000007200, 10'd470, 1'b0, 10'd820, 1'b0, 19'd273149);
		send_fields(16'h4341, 41'd42, 10'd9, 1'b1, 10'd9, 1'b1, 19'd200000);

		// Random phases: free flow, idle sender, stalling receiver, both.
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = (ph == 1) ? 47 : (ph == 3) ? 32 : 0;
			stall_pct = (ph == 2) ? 47 : (ph == 3) ? 32 : 0;
			for (int n = 0; n < 360; n++) begin
				send_random();
				// Hold off until every pending result has been taken.
				if (ph == 1 && n == 180) begin
					push <= 1'b0;
					@(posedge clk);
					wait_drained();
				end
			end
		end
		push <= 1'b0;

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
